### sv/gytc_pkg.sv
// shared types, constants and angle helpers for the goal yaw trajectory cost block
package gytc_pkg;

  localparam int MAX_STEPS_DEF = 64;

  localparam int YAW_W    = 15;
  localparam int ANG_W    = 17;
  localparam int ERR_W    = 14;
  localparam int SUM_W    = 21;
  localparam int CNT_W    = 11;
  localparam int COST_W   = 32;
  localparam int WEIGHT_W = 16;
  localparam int POWER_W  = 4;
  localparam int LEN_W    = 16;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 3;

  // dividend is the sum scaled by sixteen
  localparam int DIV_W  = SUM_W + 4;
  localparam int X_W    = DIV_W + WEIGHT_W - 8;
  localparam int PROD_W = COST_W + X_W;

  localparam int Q_DEPTH = 2;

  localparam logic signed [ANG_W-1:0] PI_Q12     = 17'sd12868;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q12 = 17'sd25736;

  localparam logic [IDX_W-1:0] REG_ENABLED     = 3'd0;
  localparam logic [IDX_W-1:0] REG_WEIGHT      = 3'd1;
  localparam logic [IDX_W-1:0] REG_POWER       = 3'd2;
  localparam logic [IDX_W-1:0] REG_THRESHOLD   = 3'd3;
  localparam logic [IDX_W-1:0] REG_SYMMETRIC   = 3'd4;
  localparam logic [IDX_W-1:0] REG_GOAL_YAW    = 3'd5;
  localparam logic [IDX_W-1:0] REG_PATH_LENGTH = 3'd6;

  typedef struct packed {
    logic                       enabled;
    logic [WEIGHT_W-1:0]        weight;
    logic [POWER_W-1:0]         power;
    logic [LEN_W-1:0]           threshold;
    logic                       symmetric;
    logic signed [YAW_W-1:0]    goal_yaw;
    logic [LEN_W-1:0]           path_length;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]    count;
    logic [COST_W-1:0]   cost;
    logic                act;
    logic [POWER_W-1:0]  power;
    logic [WEIGHT_W-1:0] weight;
  } job_t;

  function automatic logic signed [ANG_W-1:0] sext_ang(input logic [YAW_W-1:0] v);
    return {{(ANG_W-YAW_W){v[YAW_W-1]}}, v};
  endfunction

  // one correction by two pi is enough for any difference of two 15-bit angles
  function automatic logic signed [ANG_W-1:0] wrap_ang(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] r;
    if (a > PI_Q12) r = a - TWO_PI_Q12;
    else if (a < -PI_Q12) r = a + TWO_PI_Q12;
    else r = a;
    return r;
  endfunction

  function automatic logic [ERR_W-1:0] abs_ang(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] n;
    n = -a;
    return a[ANG_W-1] ? n[ERR_W-1:0] : a[ERR_W-1:0];
  endfunction

endpackage

### sv/gytc_ifs.sv
// valid/ready channel interfaces for samples in and costs out
interface gytc_in_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] yaw;
  logic [31:0]        cost_in;
  logic               last;
  modport source(output valid, yaw, cost_in, last, input ready);
  modport sink(input valid, yaw, cost_in, last, output ready);
endinterface

interface gytc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cost_out;
  modport source(output valid, cost_out, input ready);
  modport sink(input valid, cost_out, output ready);
endinterface

### sv/goal_yaw_trajectory_cost.sv
// Goal heading cost for sampled trajectories. Yaw samples stream in on the samples
// channel at one beat per clock; each sample's wrapped heading error is accumulated
// in a two-stage front end that never stalls except when a row end finds the
// two-entry job queue full. Each row end becomes a job for the back end, which
// produces one beat on the costs channel. A job is popped and then, when the
// critic is active, goes through restoring division (one quotient bit per cycle),
// the weight multiply, a multiply and a saturate step for each power step above
// one and the saturating add; the result then waits in the output register until
// taken. When the cost passes through, the popped job goes straight to the output
// register. Configuration must be written through cfg_we/cfg_index/cfg_data only
// while idle, which binds the user; the block itself has no check for this.
module goal_yaw_trajectory_cost #(
  parameter int MAX_STEPS = gytc_pkg::MAX_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  gytc_in_if.sink                        samples,
  gytc_out_if.source                     costs,
  input  logic                           cfg_we,
  input  logic [gytc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [gytc_pkg::CFG_W-1:0]     cfg_data
);
  import gytc_pkg::*;

  cfg_t cfg;
  logic q_push, q_full, q_pop, q_valid;
  job_t push_job, pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled     <= 1'b1;
      cfg.weight      <= 16'd768;
      cfg.power       <= 4'd1;
      cfg.threshold   <= 16'd358;
      cfg.symmetric   <= 1'b0;
      cfg.goal_yaw    <= '0;
      cfg.path_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLED:     cfg.enabled     <= cfg_data[0];
        REG_WEIGHT:      cfg.weight      <= cfg_data[WEIGHT_W-1:0];
        REG_POWER:       cfg.power       <= cfg_data[POWER_W-1:0];
        REG_THRESHOLD:   cfg.threshold   <= cfg_data[LEN_W-1:0];
        REG_SYMMETRIC:   cfg.symmetric   <= cfg_data[0];
        REG_GOAL_YAW:    cfg.goal_yaw    <= cfg_data[YAW_W-1:0];
        REG_PATH_LENGTH: cfg.path_length <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gytc_front #(
    .MAX_STEPS(MAX_STEPS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (push_job)
  );

  gytc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (pop_job)
  );

  gytc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .costs   (costs)
  );

endmodule

### sv/gytc_front.sv
// front end: per-sample heading error, row accumulation and job hand-off
module gytc_front #(
  parameter int MAX_STEPS = gytc_pkg::MAX_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  gytc_in_if.sink          samples,
  input  gytc_pkg::cfg_t   cfg,
  input  logic             q_full,
  output logic             q_push,
  output gytc_pkg::job_t   q_job
);
  import gytc_pkg::*;

  logic                    a_valid;
  logic [ERR_W-1:0]        a_err;
  logic                    a_last;
  logic [COST_W-1:0]       a_cost;
  logic [SUM_W-1:0]        sum;
  logic [CNT_W-1:0]        count;

  logic signed [ANG_W-1:0] yaw_x, goal_x, goal_flip;
  logic [ERR_W-1:0]        err_goal, err_flip, err;
  logic                    advance, take;
  logic [SUM_W:0]          sum_wide;
  logic [SUM_W-1:0]        sum_next;
  logic [CNT_W-1:0]        count_next;

  always_comb begin
    yaw_x     = sext_ang(samples.yaw);
    goal_x    = sext_ang(cfg.goal_yaw);
    goal_flip = wrap_ang(goal_x + PI_Q12);
    err_goal  = abs_ang(wrap_ang(yaw_x - goal_x));
    err_flip  = abs_ang(wrap_ang(yaw_x - goal_flip));
    err       = (cfg.symmetric && err_flip < err_goal) ? err_flip : err_goal;
  end

  // a row end waits in stage a until the queue has room
  assign advance       = !a_valid || !(a_last && q_full);
  assign samples.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && samples.valid) begin
      a_err  <= err;
      a_last <= samples.last;
      a_cost <= samples.cost_in;
    end
  end

  always_comb begin
    take       = count < CNT_W'(MAX_STEPS);
    sum_wide   = {1'b0, sum} + (SUM_W+1)'(a_err);
    sum_next   = sum;
    count_next = count;
    if (take) begin
      sum_next   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      count_next = count + 1'b1;
    end
  end

  assign q_push       = a_valid && a_last && !q_full;
  assign q_job.sum    = sum_next;
  assign q_job.count  = count_next;
  assign q_job.cost   = a_cost;
  assign q_job.act    = cfg.enabled && (cfg.path_length <= cfg.threshold);
  assign q_job.power  = cfg.power;
  assign q_job.weight = cfg.weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (a_valid && advance) begin
      if (a_last) begin
        sum   <= '0;
        count <= '0;
      end else begin
        sum   <= sum_next;
        count <= count_next;
      end
    end
  end

endmodule

### sv/gytc_queue.sv
// short job queue between the front and back ends
module gytc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gytc_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output gytc_pkg::job_t pop_job
);
  import gytc_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int FILL_W = $clog2(Q_DEPTH + 1);

  job_t              slots [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full    = fill == FILL_W'(Q_DEPTH);
  assign valid   = fill != '0;
  assign pop_job = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

### sv/gytc_back.sv
// back end: mean by restoring division, weighting, power steps and saturating add, or pass-through of the input cost
module gytc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  gytc_pkg::job_t q_job,
  output logic           q_pop,
  gytc_out_if.source     costs
);
  import gytc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_POW    = 3'd3;
  localparam logic [2:0] S_POWSAT = 3'd4;
  localparam logic [2:0] S_ADD    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  localparam int DCNT_W = $clog2(DIV_W);

  logic [2:0]          state;
  job_t                job;
  logic [CNT_W-1:0]    rem;
  logic [DIV_W-1:0]    quo;
  logic [DCNT_W-1:0]   dcnt;
  logic [X_W-1:0]      x;
  logic [COST_W-1:0]   r;
  logic [PROD_W-1:0]   prod;
  logic [POWER_W-1:0]  k;
  logic [COST_W-1:0]   res;

  logic [CNT_W:0]                  trial;
  logic                            qbit;
  logic [DIV_W+WEIGHT_W-1:0]       scaled;
  logic [X_W-1:0]                  x_next;
  logic [PROD_W-1:0]               prod_next;
  logic [PROD_W-17:0]              shifted;
  logic [POWER_W-1:0]              k_next;
  logic [COST_W:0]                 total;

  always_comb begin
    trial     = {rem, quo[DIV_W-1]};
    qbit      = trial >= {1'b0, job.count};
    scaled    = quo * job.weight;
    x_next    = scaled[DIV_W+WEIGHT_W-1:8];
    // x is one bit wider than a 32-bit multiplier, its top bit adds r shifted up
    prod_next = PROD_W'(r * x[COST_W-1:0])
              + (x[X_W-1] ? PROD_W'({r, {COST_W{1'b0}}}) : '0);
    shifted   = prod[PROD_W-1:16];
    k_next    = k + 1'b1;
    total     = {1'b0, job.cost} + {1'b0, r};
  end

  assign q_pop          = (state == S_IDLE) && q_valid;
  assign costs.valid    = state == S_OUT;
  assign costs.cost_out = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_job.act && q_job.count != '0) state <= S_DIV;
            else state <= S_OUT;
          end
        end
        S_DIV: begin
          if (dcnt == DCNT_W'(DIV_W - 1)) state <= S_MUL;
        end
        S_MUL: begin
          state <= (job.power > POWER_W'(1)) ? S_POW : S_ADD;
        end
        S_POW: begin
          state <= S_POWSAT;
        end
        S_POWSAT: begin
          state <= (k_next < job.power) ? S_POW : S_ADD;
        end
        S_ADD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (costs.ready) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        job  <= q_job;
        rem  <= '0;
        quo  <= {q_job.sum, 4'b0000};
        dcnt <= '0;
        res  <= q_job.cost;
      end
      S_DIV: begin
        rem  <= qbit ? CNT_W'(trial - {1'b0, job.count}) : trial[CNT_W-1:0];
        quo  <= {quo[DIV_W-2:0], qbit};
        dcnt <= dcnt + 1'b1;
      end
      S_MUL: begin
        x <= x_next;
        r <= x_next[X_W-1] ? {COST_W{1'b1}} : x_next[COST_W-1:0];
        k <= POWER_W'(1);
      end
      S_POW: begin
        prod <= prod_next;
      end
      S_POWSAT: begin
        r <= (|shifted[PROD_W-17:COST_W]) ? {COST_W{1'b1}} : shifted[COST_W-1:0];
        k <= k_next;
      end
      S_ADD: begin
        res <= total[COST_W] ? {COST_W{1'b1}} : total[COST_W-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

### tb/tb_goal_yaw_trajectory_cost.sv
// self-checking testbench for the goal yaw trajectory cost block
`timescale 1ns / 1ps

module tb_goal_yaw_trajectory_cost;
  import gytc_pkg::*;

  localparam int ROW_LIMIT      = 64;
  localparam int HALF_TURN      = 12868;
  localparam int FULL_TURN      = 25736;
  localparam longint unsigned SUM_CEIL = 64'h1F_FFFF;
  localparam longint unsigned U32_MAX  = 64'hFFFF_FFFF;
  // the longest job is one at power fifteen, with fourteen power steps
  localparam int SETTLE_CYCLES  = 100;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_t;

  typedef struct packed {
    logic signed [YAW_W-1:0] yaw;
    logic [COST_W-1:0]       cost_in;
    logic                    last;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  gytc_in_if  samples_if();
  gytc_out_if costs_if();

  goal_yaw_trajectory_cost #(.MAX_STEPS(ROW_LIMIT)) u_top (
    .clk(clk),
    .rst(rst),
    .samples(samples_if),
    .costs(costs_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_t           sample_queue[$];
  logic [COST_W-1:0] cost_expect[$];
  sample_t           on_wire;
  sample_t           next_beat;
  logic [COST_W-1:0] want;
  cfg_t              shadow;
  longint unsigned   row_sum;
  longint unsigned   row_count;
  pace_t             pace;
  int                tx_idle_pct;
  int                rx_idle_pct;
  bit                squeeze_on;
  int                squeeze_cnt;
  int                stall_cnt;
  int                errors;

  always_comb begin
    case (pace)
      PACE_RX_SLOW: begin tx_idle_pct = 9;  rx_idle_pct = 88; end
      PACE_TX_SLOW: begin tx_idle_pct = 88; rx_idle_pct = 9;  end
      default:      begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
    endcase
  end

  function automatic int wrap_half_turn(input int a);
    int i;
    for (i = 0; i < 4; i++) begin
      if (a > HALF_TURN) a -= FULL_TURN;
      else if (a < -HALF_TURN) a += FULL_TURN;
    end
    return a;
  endfunction

  function automatic int heading_error(input int target, input int yaw);
    int d;
    d = wrap_half_turn(yaw - target);
    return (d < 0) ? -d : d;
  endfunction

  // folds one accepted sample into the row and queues the cost at row end
  function automatic void predict_cost(input sample_t s);
    int err;
    int alt_err;
    int k;
    longint unsigned mean;
    longint unsigned scaled;
    longint unsigned powered;
    longint unsigned total;
    if (row_count < ROW_LIMIT) begin
      err = heading_error(shadow.goal_yaw, s.yaw);
      if (shadow.symmetric) begin
        alt_err = heading_error(wrap_half_turn(shadow.goal_yaw + HALF_TURN), s.yaw);
        if (alt_err < err) err = alt_err;
      end
      row_sum += err;
      if (row_sum > SUM_CEIL) row_sum = SUM_CEIL;
      row_count++;
    end
    if (s.last) begin
      total = s.cost_in;
      if (shadow.enabled && shadow.path_length <= shadow.threshold && row_count != 0) begin
        mean = (row_sum * 16) / row_count;
        scaled = (mean * shadow.weight) >> 8;
        powered = (scaled > U32_MAX) ? U32_MAX : scaled;
        for (k = 1; k < shadow.power; k++) begin
          powered = (powered * scaled) >> 16;
          if (powered > U32_MAX) powered = U32_MAX;
        end
        total += powered;
        if (total > U32_MAX) total = U32_MAX;
      end
      row_sum = 0;
      row_count = 0;
      cost_expect.push_back(total[31:0]);
    end
  endfunction

  // driver: holds a beat until taken, then offers the next pending sample
  always @(posedge clk) begin
    if (rst) begin
      samples_if.valid <= 1'b0;
    end else if (!samples_if.valid || samples_if.ready) begin
      if (samples_if.valid) predict_cost(on_wire);
      if (sample_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        next_beat = sample_queue.pop_front();
        on_wire <= next_beat;
        samples_if.yaw <= next_beat.yaw;
        samples_if.cost_in <= next_beat.cost_in;
        samples_if.last <= next_beat.last;
        samples_if.valid <= 1'b1;
      end else begin
        samples_if.valid <= 1'b0;
      end
    end
  end

  // monitor: checks each cost beat against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      costs_if.ready <= 1'b0;
      squeeze_cnt <= 0;
    end else begin
      if (costs_if.valid && costs_if.ready) begin
        if (cost_expect.size() == 0) begin
          $error("cost_out: nothing expected, got %08h", costs_if.cost_out);
          errors++;
        end else begin
          want = cost_expect.pop_front();
          if (costs_if.cost_out !== want) begin
            $error("cost_out: expected %08h, got %08h", want, costs_if.cost_out);
            errors++;
          end
        end
      end
      if (squeeze_on && squeeze_cnt < SQUEEZE_CYCLES) begin
        costs_if.ready <= 1'b0;
        squeeze_cnt <= squeeze_cnt + 1;
      end else begin
        costs_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((samples_if.valid && samples_if.ready) || (costs_if.valid && costs_if.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic push_sample(input logic [YAW_W-1:0] yaw, input logic [COST_W-1:0] cost,
                             input logic last);
    sample_t s;
    s.yaw = yaw;
    s.cost_in = cost;
    s.last = last;
    sample_queue.push_back(s);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (sample_queue.size() != 0 || samples_if.valid || cost_expect.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ENABLED:     shadow.enabled = val[0];
      REG_WEIGHT:      shadow.weight = val;
      REG_POWER:       shadow.power = val[POWER_W-1:0];
      REG_THRESHOLD:   shadow.threshold = val;
      REG_SYMMETRIC:   shadow.symmetric = val[0];
      REG_GOAL_YAW:    shadow.goal_yaw = val[YAW_W-1:0];
      REG_PATH_LENGTH: shadow.path_length = val;
      default: ;
    endcase
  endtask

  task automatic program_cfg(input logic en, input logic [15:0] wt, input logic [3:0] pw,
                             input logic [15:0] thr, input logic sym,
                             input logic [14:0] goal, input logic [15:0] plen);
    set_reg(REG_ENABLED, {15'd0, en});
    set_reg(REG_WEIGHT, wt);
    set_reg(REG_POWER, {12'd0, pw});
    set_reg(REG_THRESHOLD, thr);
    set_reg(REG_SYMMETRIC, {15'd0, sym});
    set_reg(REG_GOAL_YAW, {goal[14], goal});
    set_reg(REG_PATH_LENGTH, plen);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_cfg();
    logic        en;
    logic [15:0] wt;
    logic [3:0]  pw;
    logic [15:0] thr;
    logic        sym;
    logic [14:0] goal;
    logic [15:0] plen;
    en = ($urandom_range(0, 7) != 0);
    wt = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 1024)) : 16'($urandom);
    pw = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    thr = 16'($urandom);
    sym = 1'($urandom);
    // mostly a goal inside the half turn, now and then any 15-bit pattern
    goal = ($urandom_range(0, 4) != 0) ? 15'($urandom_range(0, FULL_TURN) - HALF_TURN)
                                       : 15'($urandom);
    plen = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, thr)) : 16'($urandom);
    program_cfg(en, wt, pw, thr, sym, goal, plen);
  endtask

  // whole rows with random content; a few run past the row limit
  task automatic random_rows(input int n_items, input bit short_rows);
    int done;
    int len;
    int r;
    int i;
    logic [YAW_W-1:0]  yaw;
    logic [COST_W-1:0] cost;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (short_rows) len = $urandom_range(1, 3);
      else if (r < 65) len = $urandom_range(1, 6);
      else if (r < 90) len = $urandom_range(7, 30);
      else if (r < 97) len = $urandom_range(ROW_LIMIT - 4, ROW_LIMIT + 4);
      else len = $urandom_range(ROW_LIMIT + 5, ROW_LIMIT + 26);
      for (i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0, 1: yaw = YAW_W'($urandom);
          2: yaw = YAW_W'(shadow.goal_yaw + $urandom_range(0, 64) - 32);
          3: yaw = YAW_W'(shadow.goal_yaw + HALF_TURN + $urandom_range(0, 64) - 32);
          default: yaw = YAW_W'($urandom_range(0, FULL_TURN) - HALF_TURN);
        endcase
        case ($urandom_range(0, 7))
          0: cost = '0;
          1: cost = '1;
          2: cost = $urandom | 32'hFFFF_0000;
          default: cost = $urandom;
        endcase
        push_sample(yaw, cost, i == len - 1);
      end
      done += len;
    end
  endtask

  initial begin
    int p;
    samples_if.valid = 1'b0;
    samples_if.yaw = '0;
    samples_if.cost_in = '0;
    samples_if.last = 1'b0;
    costs_if.ready = 1'b0;
    errors = 0;
    stall_cnt = 0;
    squeeze_on = 1'b0;
    pace = PACE_RX_SLOW;
    shadow.enabled = 1'b1;
    shadow.weight = 16'd768;
    shadow.power = 4'd1;
    shadow.threshold = 16'd358;
    shadow.symmetric = 1'b0;
    shadow.goal_yaw = '0;
    shadow.path_length = '0;
    row_sum = 0;
    row_count = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: yaw extremes, out-of-range yaw, cost saturation
    push_sample(15'd0, 32'h0000_0000, 1'b1);
    push_sample(15'd12868, 32'h0000_0000, 1'b1);
    push_sample(-15'sd12868, 32'h0000_0001, 1'b1);
    push_sample(15'h3FFF, 32'hFFFF_FFFF, 1'b1);
    push_sample(15'h4000, 32'h8000_0000, 1'b1);
    push_sample(15'd12869, 32'hAAAA_AAAA, 1'b0);
    push_sample(-15'sd12869, 32'h5555_5555, 1'b0);
    push_sample(15'd6434, 32'h1234_5678, 1'b1);
    push_sample(15'd1, 32'hFFFF_FFFF, 1'b0);
    push_sample(15'h7FFF, 32'h0000_0000, 1'b1);
    push_sample(15'h2AAA, 32'hFFFF_0000, 1'b0);
    push_sample(15'h5555, 32'h0000_FFFF, 1'b1);
    push_sample(15'd12868, 32'hFFFF_FF00, 1'b1);
    wait_drained();

    // all maxima: path equal to threshold, exponent past the usual range
    program_cfg(1'b1, 16'hFFFF, 4'hF, 16'hFFFF, 1'b1, 15'h3FFF, 16'hFFFF);
    random_rows(40, 1'b0);
    wait_drained();

    program_cfg(1'b0, 16'h0000, 4'h0, 16'h0000, 1'b0, 15'h4000, 16'h0000);
    random_rows(30, 1'b0);
    wait_drained();

    // path longer than threshold
    program_cfg(1'b1, 16'd768, 4'd2, 16'd100, 1'b0, 15'd0, 16'd200);
    random_rows(30, 1'b0);
    wait_drained();

    random_cfg();
    random_rows(110, 1'b0);
    wait_drained();

    pace = PACE_TX_SLOW;
    program_cfg(1'b1, 16'h0000, 4'h0, 16'hFFFF, 1'b1, -15'sd12868, 16'hFFFF);
    random_rows(30, 1'b0);
    wait_drained();

    for (p = 0; p < 3; p++) begin
      if (p == 2) pace = PACE_FULL;
      random_cfg();
      random_rows(110, 1'b0);
      wait_drained();
    end

    // short rows while the cost side holds off, so the job queue fills
    random_cfg();
    squeeze_on = 1'b1;
    random_rows(60, 1'b1);
    wait_drained();

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
sv/gytc_pkg.sv
sv/gytc_ifs.sv
sv/gytc_front.sv
sv/gytc_queue.sv
sv/gytc_back.sv
sv/goal_yaw_trajectory_cost.sv
tb/tb_goal_yaw_trajectory_cost.sv
